### rtl/wtsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared types and constants for the world-to-screen projection pipeline.
// ----------------------------------------------------------------------------
package wtsp_pkg;

    // Fraction bits of the quotient n / w and integer bits kept before it saturates.
    localparam int QUOT_FRAC = 24;
    localparam int INT_BITS  = 21;

    localparam int SIZE_W = 14;
    localparam int SCR_W  = 24;

    localparam logic [SCR_W-1:0] SCR_MAX = 24'h7F_FFFF;
    localparam logic [SCR_W-1:0] SCR_MIN = 24'h80_0000;

    localparam int CFG_AW = 6;
    localparam int CFG_DW = 64;

    typedef enum logic [2:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW3_COLS01 = 3'd4,
        REG_ROW3_COLS23 = 3'd5,
        REG_SCREEN_W    = 3'd6,
        REG_SCREEN_H    = 3'd7
    } cfg_reg_t;

endpackage
`default_nettype wire

### rtl/world_to_screen_projection.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Perspective projection of world points to signed Q20.4 screen pixels.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_world_x, s_world_y, s_world_z
// m_        out        m_valid / m_ready    m_in_front, m_screen_x, m_screen_y
// APB       in         psel/penable/pready  paddr, pwdata, prdata (64 bit)
//
// One item enters every cycle while the output is not stalled; each item passes through
// the 45-stage pipelined long division (one quotient bit per stage) on its way to the output.
// Reset clears the valid bits and loads the register reset values.
// The whole pipeline holds while a result waits at the output and m_ready is low.
// ----------------------------------------------------------------------------
module world_to_screen_projection
    import wtsp_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [CFG_AW-1:0]    paddr,
    input  wire logic [CFG_DW-1:0]    pwdata,
    output logic      [CFG_DW-1:0]    prdata,
    output logic                      pready,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [31:0]   s_world_x,
    input  wire logic signed [31:0]   s_world_y,
    input  wire logic signed [31:0]   s_world_z,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_in_front,
    output logic signed [SCR_W-1:0]   m_screen_x,
    output logic signed [SCR_W-1:0]   m_screen_y
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int SPW = 64 - F;
    localparam int PW  = SPW + 2;
    localparam int AW  = PW + 1;
    localparam int DW  = PW - 1;
    localparam int QB  = INT_BITS + QUOT_FRAC;
    localparam int CW  = DW + QB;
    localparam int MW  = QB + SIZE_W + 3;
    localparam int GW  = MW - QUOT_FRAC + 1;
    localparam logic signed [PW-1:0] W_MIN =
        PW'(((64'd1 << F) + 64'd999) / 64'd1000);

    // ---------------- configuration ----------------
    logic [63:0]       mat_reg [6];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    cfg_reg_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_reg_t'(paddr[CFG_AW-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) mat_reg[i] <= '0;
            width_reg  <= SIZE_W'(1920);
            height_reg <= SIZE_W'(1080);
        end else if (psel && penable && pwrite) begin
            unique case (cfg_idx)
                REG_SCREEN_W: width_reg  <= pwdata[SIZE_W-1:0];
                REG_SCREEN_H: height_reg <= pwdata[SIZE_W-1:0];
                default:      mat_reg[cfg_idx] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SCREEN_W: prdata = CFG_DW'(width_reg);
            REG_SCREEN_H: prdata = CFG_DW'(height_reg);
            default:      prdata = mat_reg[cfg_idx];
        endcase
    end

    // Matrix rows 0, 1 and 3 as signed entries; row slot 2 holds w.
    logic signed [31:0] mat [3][4];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            mat[r][0] = mat_reg[2*r][31:0];
            mat[r][1] = mat_reg[2*r][63:32];
            mat[r][2] = mat_reg[2*r+1][31:0];
            mat[r][3] = mat_reg[2*r+1][63:32];
        end
    end

    // ---------------- pipeline control ----------------
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, vm_reg;
    logic dv_reg [QB+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            vm_reg  <= 1'b0;
            m_valid <= 1'b0;
            for (int j = 0; j <= QB; j++) dv_reg[j] <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int j = 0; j < QB; j++) dv_reg[j+1] <= dv_reg[j];
            vm_reg    <= dv_reg[QB];
            m_valid   <= vm_reg;
        end
    end

    // ---------------- stage 1: input register ----------------
    logic signed [31:0] crd_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            crd_reg[0] <= s_world_x;
            crd_reg[1] <= s_world_y;
            crd_reg[2] <= s_world_z;
        end
    end

    // ---------------- stage 2: products ----------------
    logic signed [63:0] prod_reg [3][3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= 64'(mat[r][c]) * 64'(crd_reg[c]);
        end
    end

    // ---------------- stage 3: row sums ----------------
    logic signed [PW-1:0] dot_reg [3];
    logic signed [63:0]   sh [3][3];
    logic signed [PW-1:0] dot_next [3];
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) sh[r][c] = prod_reg[r][c] >>> F;
            dot_next[r] = PW'(sh[r][0]) + PW'(sh[r][1]) + PW'(sh[r][2])
                        + PW'(mat[r][3]);
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) dot_reg[r] <= dot_next[r];
        end
    end

    // ---------------- stage 4: numerators ----------------
    logic signed [AW-1:0] n_next [2];
    logic [AW-1:0]        mag_reg [2];
    logic                 sgn_reg [2];
    logic [DW-1:0]        d4_reg;
    logic                 front4_reg;
    assign n_next[0] = AW'(dot_reg[2]) + AW'(dot_reg[0]);
    assign n_next[1] = AW'(dot_reg[2]) - AW'(dot_reg[1]);
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 2; c++) begin
                sgn_reg[c] <= n_next[c][AW-1];
                mag_reg[c] <= n_next[c][AW-1] ? AW'(-n_next[c]) : AW'(n_next[c]);
            end
            d4_reg     <= dot_reg[2][DW-1:0];
            front4_reg <= dot_reg[2] >= W_MIN;
        end
    end

    // ---------------- division: stage 5 loads, then one bit per stage ----------------
    logic [CW-1:0] rem_reg [QB+1][2];
    logic [QB-1:0] q_reg   [QB+1][2];
    logic          ovf_reg [QB+1][2];
    logic          neg_reg [QB+1][2];
    logic [DW-1:0] d_reg   [QB+1];
    logic          fr_reg  [QB+1];

    always_ff @(posedge aclk) begin
        logic [CW-1:0] dsh;
        if (en) begin
            for (int c = 0; c < 2; c++) begin
                rem_reg[0][c] <= CW'(mag_reg[c]) << QUOT_FRAC;
                q_reg[0][c]   <= '0;
                ovf_reg[0][c] <= CW'(mag_reg[c]) >= (CW'(d4_reg) << INT_BITS);
                neg_reg[0][c] <= sgn_reg[c];
            end
            d_reg[0]  <= d4_reg;
            fr_reg[0] <= front4_reg;
            // Stage j compares against the divisor shifted to quotient bit QB-1-j.
            for (int j = 0; j < QB; j++) begin
                dsh = CW'(d_reg[j]) << (QB - 1 - j);
                for (int c = 0; c < 2; c++) begin
                    if (rem_reg[j][c] >= dsh) begin
                        rem_reg[j+1][c] <= rem_reg[j][c] - dsh;
                        q_reg[j+1][c]   <= {q_reg[j][c][QB-2:0], 1'b1};
                    end else begin
                        rem_reg[j+1][c] <= rem_reg[j][c];
                        q_reg[j+1][c]   <= {q_reg[j][c][QB-2:0], 1'b0};
                    end
                    ovf_reg[j+1][c] <= ovf_reg[j][c];
                    neg_reg[j+1][c] <= neg_reg[j][c];
                end
                d_reg[j+1]  <= d_reg[j];
                fr_reg[j+1] <= fr_reg[j];
            end
        end
    end

    // ---------------- scale by 8 * size ----------------
    logic [MW-1:0] mul_reg [2];
    logic          ovfm_reg [2];
    logic          negm_reg [2];
    logic          frm_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            mul_reg[0] <= MW'(q_reg[QB][0]) * MW'({width_reg, 3'b000});
            mul_reg[1] <= MW'(q_reg[QB][1]) * MW'({height_reg, 3'b000});
            for (int c = 0; c < 2; c++) begin
                ovfm_reg[c] <= ovf_reg[QB][c];
                negm_reg[c] <= neg_reg[QB][c];
            end
            frm_reg <= fr_reg[QB];
        end
    end

    // ---------------- round, saturate, output register ----------------
    logic [MW:0]      rnd [2];
    logic [GW-1:0]    g   [2];
    logic [SCR_W-1:0] scr_next [2];
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            rnd[c] = (MW+1)'(mul_reg[c]) + ((MW+1)'(1) << (QUOT_FRAC - 1));
            g[c]   = rnd[c][MW:QUOT_FRAC];
            if (!frm_reg) begin
                scr_next[c] = '0;
            end else if (ovfm_reg[c]) begin
                scr_next[c] = negm_reg[c] ? SCR_MIN : SCR_MAX;
            end else if (negm_reg[c]) begin
                scr_next[c] = (g[c] > GW'(SCR_MIN)) ? SCR_MIN : SCR_W'(-g[c]);
            end else begin
                scr_next[c] = (g[c] > GW'(SCR_MAX)) ? SCR_MAX : g[c][SCR_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_in_front <= frm_reg;
            m_screen_x <= scr_next[0];
            m_screen_y <= scr_next[1];
        end
    end

endmodule
`default_nettype wire
